// File: hw/rtl/bmp_pkg.sv
// Shared types, widths and the control store of the binomial mod prime block.
// No dependencies; imported by bmp_mulmod and binomial_mod_prime_core.
`default_nettype none

package bmp_pkg;

    // Field widths
    localparam int COUNT_BITS = 20;
    localparam int MOD_BITS   = 31;

    // Multiplier operand b carries either a count or a residue
    localparam int MUL_B_BITS = (COUNT_BITS > MOD_BITS) ? COUNT_BITS : MOD_BITS;
    localparam int MUL_CNT_BITS = $clog2(MUL_B_BITS + 1);

    // Stream and register port widths
    localparam int S_TDATA_BITS = ((2 * COUNT_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((MOD_BITS + 7) / 8) * 8;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

    // Register index of the modulus
    localparam logic REG_MODULUS = 1'b0;

    // Microcode
    localparam int PC_BITS = 4;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD_IN,
        ACT_MUL,
        ACT_POW_INIT,
        ACT_ZERO_RES,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        MS_FALL_TERM,
        MS_FACT_TERM,
        MS_ACC_SQ,
        MS_SQ_SQ,
        MS_FINAL
    } msel_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_BAD,
        C_I_DONE,
        C_EXP_ZERO,
        C_EXP_EVEN
    } cond_t;

    typedef struct packed {
        act_t               act;
        msel_t              msel;
        cond_t              cond;
        logic [PC_BITS-1:0] target;
    } ctrl_t;

    // Step addresses
    localparam logic [PC_BITS-1:0] ST_LOAD     = PC_BITS'(0);
    localparam logic [PC_BITS-1:0] ST_CHECK    = PC_BITS'(1);
    localparam logic [PC_BITS-1:0] ST_TERM_TOP = PC_BITS'(2);
    localparam logic [PC_BITS-1:0] ST_MUL_FALL = PC_BITS'(3);
    localparam logic [PC_BITS-1:0] ST_MUL_FACT = PC_BITS'(4);
    localparam logic [PC_BITS-1:0] ST_POW_INIT = PC_BITS'(5);
    localparam logic [PC_BITS-1:0] ST_POW_TOP  = PC_BITS'(6);
    localparam logic [PC_BITS-1:0] ST_POW_BIT  = PC_BITS'(7);
    localparam logic [PC_BITS-1:0] ST_MUL_ACC  = PC_BITS'(8);
    localparam logic [PC_BITS-1:0] ST_MUL_SQ   = PC_BITS'(9);
    localparam logic [PC_BITS-1:0] ST_FINAL    = PC_BITS'(10);
    localparam logic [PC_BITS-1:0] ST_ZERO     = PC_BITS'(11);
    localparam logic [PC_BITS-1:0] ST_EMIT     = PC_BITS'(12);

    function automatic ctrl_t mk_word(input act_t act, input msel_t msel,
                                      input cond_t cond,
                                      input logic [PC_BITS-1:0] target);
        ctrl_t w;
        w.act    = act;
        w.msel   = msel;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store: one word per step
    function automatic ctrl_t ucode_word(input logic [PC_BITS-1:0] pc);
        ctrl_t w;
        case (pc)
            ST_LOAD:     w = mk_word(ACT_LOAD_IN,  MS_FALL_TERM, C_NEXT,     ST_LOAD);
            ST_CHECK:    w = mk_word(ACT_NONE,     MS_FALL_TERM, C_BAD,      ST_ZERO);
            ST_TERM_TOP: w = mk_word(ACT_NONE,     MS_FALL_TERM, C_I_DONE,   ST_POW_INIT);
            ST_MUL_FALL: w = mk_word(ACT_MUL,      MS_FALL_TERM, C_NEXT,     ST_LOAD);
            ST_MUL_FACT: w = mk_word(ACT_MUL,      MS_FACT_TERM, C_ALWAYS,   ST_TERM_TOP);
            ST_POW_INIT: w = mk_word(ACT_POW_INIT, MS_FALL_TERM, C_NEXT,     ST_LOAD);
            ST_POW_TOP:  w = mk_word(ACT_NONE,     MS_FALL_TERM, C_EXP_ZERO, ST_FINAL);
            ST_POW_BIT:  w = mk_word(ACT_NONE,     MS_FALL_TERM, C_EXP_EVEN, ST_MUL_SQ);
            ST_MUL_ACC:  w = mk_word(ACT_MUL,      MS_ACC_SQ,    C_NEXT,     ST_LOAD);
            ST_MUL_SQ:   w = mk_word(ACT_MUL,      MS_SQ_SQ,     C_ALWAYS,   ST_POW_TOP);
            ST_FINAL:    w = mk_word(ACT_MUL,      MS_FINAL,     C_ALWAYS,   ST_EMIT);
            ST_ZERO:     w = mk_word(ACT_ZERO_RES, MS_FALL_TERM, C_NEXT,     ST_LOAD);
            ST_EMIT:     w = mk_word(ACT_EMIT,     MS_FALL_TERM, C_ALWAYS,   ST_LOAD);
            default:     w = mk_word(ACT_NONE,     MS_FALL_TERM, C_ALWAYS,   ST_LOAD);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bmp_mulmod.sv
// Bit-serial interleaved modular multiplier: product = a * b mod modulus.
// Depends on bmp_pkg. Needs a < modulus; b may be any MUL_B_BITS value.
`default_nettype none

module bmp_mulmod
    import bmp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [MOD_BITS-1:0]   modulus,
    input  wire logic [MOD_BITS-1:0]   a,
    input  wire logic [MUL_B_BITS-1:0] b,
    output logic                       done,
    output logic [MOD_BITS-1:0]        product
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [MUL_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [MOD_BITS-1:0]     a_reg, a_next;
    logic [MUL_B_BITS-1:0]   b_reg, b_next;
    logic [MOD_BITS-1:0]     acc_reg, acc_next;

    logic [MOD_BITS+1:0] sum;
    logic [MOD_BITS+1:0] p1;
    logic [MOD_BITS+1:0] p2;
    logic [MOD_BITS+1:0] reduced;

    // One bit of b per cycle, MSB first: acc = 2*acc + bit*a, then reduce (< 3p)
    always_comb begin
        p1  = {2'b00, modulus};
        p2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, acc_reg, 1'b0}
            + (b_reg[MUL_B_BITS-1] ? {2'b00, a_reg} : '0);
        if (sum >= p2) begin
            reduced = sum - p2;
        end else if (sum >= p1) begin
            reduced = sum - p1;
        end else begin
            reduced = sum;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = MUL_CNT_BITS'(MUL_B_BITS);
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = reduced[MOD_BITS-1:0];
            b_next   = {b_reg[MUL_B_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - MUL_CNT_BITS'(1);
            if (cnt_reg == MUL_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// File: hw/rtl/binomial_mod_prime_core.sv
// Binomial coefficient C(n, r) mod a configured prime, microcoded top level.
// Depends on bmp_pkg (types, control store) and bmp_mulmod (shared multiplier).
//
// Usage:
//   s_ channel: one item carries n (total_count) and r (choose_count).
//   m_ channel: one item per input, the coefficient C(n, r) mod p, or 0 when
//   r > n or p < 2. The modulus register sits at APB address 0; the user must
//   write it only while the block is idle, which the block does not enforce.
//   One item is processed at a time. With k = min(r, n - r), L the bit length
//   of p - 2 (at most 31) and w its set bits, the time from an item's accept
//   to its emit step grows with k, L and w; r > n or p < 2 goes straight to
//   the zero and emit steps. A multiply step is a start, the bits of b, MSB
//   first, and done; the shared multiplier (one bit of b per cycle) sets the pace.
//   The result goes to an output register, so the next item is taken while a
//   result still waits; the sequencer only stalls at its emit step when a
//   second result is ready and the receiver has not taken the first.
//   Reset (aresetn low, synchronous) returns the step counter to the load
//   step, holds s_tready low, drops m_tvalid and reloads the modulus with
//   1000000007.
`default_nettype none

module binomial_mod_prime_core
    import bmp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // [19:0] total_count, [39:20] choose_count
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_BITS-1:0]  s_tdata,
    // [30:0] coefficient, upper bits zero
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]       m_tdata,
    // Configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    // Control
    logic [PC_BITS-1:0]  pc_reg, pc_next;
    logic                mul_run_reg, mul_run_next;
    logic                out_valid_reg, out_valid_next;
    logic [MOD_BITS-1:0] modulus_reg;

    // Datapath
    logic [COUNT_BITS-1:0] n_reg, n_next;
    logic [COUNT_BITS-1:0] r_reg, r_next;
    logic [COUNT_BITS-1:0] i_reg, i_next;
    logic                  bad_reg, bad_next;
    logic [MOD_BITS-1:0]   fall_reg, fall_next;
    logic [MOD_BITS-1:0]   fact_reg, fact_next;
    logic [MOD_BITS-1:0]   acc_reg, acc_next;
    logic [MOD_BITS-1:0]   sq_reg, sq_next;
    logic [MOD_BITS-1:0]   exp_reg, exp_next;
    logic [MOD_BITS-1:0]   res_reg, res_next;
    logic [MOD_BITS-1:0]   coef_reg, coef_next;

    ctrl_t                 cw;
    logic                  go;
    logic                  jump;
    logic                  mul_start;
    logic                  mul_done;
    logic [MOD_BITS-1:0]   mul_a;
    logic [MUL_B_BITS-1:0] mul_b;
    logic [MOD_BITS-1:0]   mul_p;
    logic [MOD_BITS-1:0]   res_next_mul;

    logic [COUNT_BITS-1:0] in_n;
    logic [COUNT_BITS-1:0] in_r;
    logic [COUNT_BITS-1:0] in_nr;
    logic                  cfg_wr;

    localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);
    localparam logic [MOD_BITS-1:0] TWO = MOD_BITS'(2);

    assign in_n  = s_tdata[COUNT_BITS-1:0];
    assign in_r  = s_tdata[2*COUNT_BITS-1:COUNT_BITS];
    assign in_nr = in_n - in_r;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_wr && paddr[2] == REG_MODULUS) begin
            modulus_reg <= pwdata[MOD_BITS-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_MODULUS) begin
            prdata = APB_DATA_BITS'(modulus_reg);
        end else begin
            prdata = '0;
        end
    end

    // Current control word
    assign cw = ucode_word(pc_reg);

    // Step completion
    always_comb begin
        case (cw.act)
            ACT_LOAD_IN: go = s_tvalid;
            ACT_MUL:     go = mul_run_reg && mul_done;
            ACT_EMIT:    go = !out_valid_reg || m_tready;
            default:     go = 1'b1;
        endcase
    end

    // Jump condition
    always_comb begin
        case (cw.cond)
            C_ALWAYS:   jump = 1'b1;
            C_BAD:      jump = bad_reg;
            C_I_DONE:   jump = (i_reg == r_reg);
            C_EXP_ZERO: jump = (exp_reg == '0);
            C_EXP_EVEN: jump = !exp_reg[0];
            default:    jump = 1'b0;
        endcase
    end

    // Step counter
    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            pc_next = jump ? cw.target : pc_reg + PC_BITS'(1);
        end
    end

    assign s_tready = (cw.act == ACT_LOAD_IN) && aresetn;

    // Multiplier operand selection
    always_comb begin
        case (cw.msel)
            MS_FALL_TERM: begin
                mul_a = fall_reg;
                mul_b = MUL_B_BITS'(n_reg - i_reg);
            end
            MS_FACT_TERM: begin
                mul_a = fact_reg;
                mul_b = MUL_B_BITS'(i_reg + COUNT_BITS'(1));
            end
            MS_ACC_SQ: begin
                mul_a = acc_reg;
                mul_b = MUL_B_BITS'(sq_reg);
            end
            MS_SQ_SQ: begin
                mul_a = sq_reg;
                mul_b = MUL_B_BITS'(sq_reg);
            end
            MS_FINAL: begin
                mul_a = fall_reg;
                mul_b = MUL_B_BITS'(acc_reg);
            end
            default: begin
                mul_a = fall_reg;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = (cw.act == ACT_MUL) && !mul_run_reg;

    always_comb begin
        mul_run_next = mul_run_reg;
        if (mul_start) begin
            mul_run_next = 1'b1;
        end else if (mul_done) begin
            mul_run_next = 1'b0;
        end
    end

    assign mul_p = modulus_reg;

    bmp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .modulus (mul_p),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (res_next_mul)
    );

    // Datapath updates, one action per step
    always_comb begin
        n_next    = n_reg;
        r_next    = r_reg;
        i_next    = i_reg;
        bad_next  = bad_reg;
        fall_next = fall_reg;
        fact_next = fact_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        exp_next  = exp_reg;
        res_next  = res_reg;
        coef_next = coef_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (go) begin
            case (cw.act)
                ACT_LOAD_IN: begin
                    n_next    = in_n;
                    r_next    = (in_r > in_nr) ? in_nr : in_r;
                    bad_next  = (in_r > in_n) || (modulus_reg < TWO);
                    i_next    = '0;
                    fall_next = ONE;
                    fact_next = ONE;
                end
                ACT_MUL: begin
                    case (cw.msel)
                        MS_FALL_TERM: fall_next = res_next_mul;
                        MS_FACT_TERM: begin
                            fact_next = res_next_mul;
                            i_next    = i_reg + COUNT_BITS'(1);
                        end
                        MS_ACC_SQ:    acc_next = res_next_mul;
                        MS_SQ_SQ: begin
                            sq_next  = res_next_mul;
                            exp_next = exp_reg >> 1;
                        end
                        MS_FINAL:     res_next = res_next_mul;
                        default:      res_next = res_reg;
                    endcase
                end
                ACT_POW_INIT: begin
                    acc_next = ONE;
                    sq_next  = fact_reg;
                    exp_next = modulus_reg - TWO;
                end
                ACT_ZERO_RES: res_next = '0;
                ACT_EMIT: begin
                    coef_next      = res_reg;
                    out_valid_next = 1'b1;
                end
                default: res_next = res_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= ST_LOAD;
            mul_run_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            mul_run_reg   <= mul_run_next;
            out_valid_reg <= out_valid_next;
        end
        n_reg    <= n_next;
        r_reg    <= r_next;
        i_reg    <= i_next;
        bad_reg  <= bad_next;
        fall_reg <= fall_next;
        fact_reg <= fact_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
        coef_reg <= coef_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'(coef_reg);

    // Assertions
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= ST_EMIT)
        else $error("step counter left the program");

    a_no_load_while_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mul_run_reg)
        else $error("input taken while a multiply is in flight");

    a_done_only_running: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> mul_run_reg)
        else $error("multiplier finished without a request");

    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && modulus_reg >= TWO) |-> (coef_reg < modulus_reg))
        else $error("coefficient not reduced below the modulus");

endmodule

`default_nettype wire
